// File: src/lkvc_pkg.sv
// shared constants and types for the lru key-value cache
`default_nettype none
package lkvc_pkg;

	localparam int CAPACITY = 16;
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int CFG_W    = 5;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int RANK_W   = IDX_W;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

	localparam logic CMD_GET = 1'b0;
	localparam logic CMD_PUT = 1'b1;

	localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

	typedef struct packed {
		logic load_req;
		logic find;
		logic apply;
	} ctrl_cmd_t;

endpackage
`default_nettype wire

// File: src/lkvc_ctrl.sv
// request sequencer: accept, lookup, apply and output handshake
`default_nettype none
module lkvc_ctrl (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output lkvc_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FIND,
		S_APPLY
	} state_t;

	state_t state_q;
	logic   out_free;

	assign out_free     = !m_tvalid || m_tready;
	assign s_tready     = (state_q == S_IDLE);
	assign cmd.load_req = s_tvalid && s_tready;
	assign cmd.find     = (state_q == S_FIND);
	assign cmd.apply    = (state_q == S_APPLY) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			m_tvalid <= 1'b0;
		end else begin
			if (cmd.apply) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						state_q <= S_FIND;
					end
				end
				S_FIND: begin
					state_q <= S_APPLY;
				end
				S_APPLY: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// a result is only written into a free output register
	a_apply_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |-> (!m_tvalid || m_tready))
		else $error("result written over a pending word");

	a_apply_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> m_tvalid)
		else $error("applied request gave no output word");

	a_accept_find: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_req |=> (cmd.find && !s_tready))
		else $error("accepted request not looked up");
`endif

endmodule
`default_nettype wire

// File: src/lkvc_datapath.sv
// entry store, key match, recency ranks and result register
`default_nettype none
module lkvc_datapath (
	input  wire                              clk,
	input  wire                              arst_n,
	input  lkvc_pkg::ctrl_cmd_t              cmd,
	input  wire                              cfg_valid,
	input  wire  [lkvc_pkg::CFG_W-1:0]       cfg_data,
	input  wire                              req_command,
	input  wire  [lkvc_pkg::KEY_W-1:0]       req_key,
	input  wire  [lkvc_pkg::VAL_W-1:0]       req_value,
	output logic                             out_hit,
	output logic [lkvc_pkg::VAL_W-1:0]       out_read_value,
	output logic                             out_evicted,
	output logic [lkvc_pkg::KEY_W-1:0]       out_evicted_key
);

	localparam int N = lkvc_pkg::CAPACITY;

	logic [lkvc_pkg::CFG_W-1:0]  cap_q;
	logic                        cmd_q;
	logic [lkvc_pkg::KEY_W-1:0]  key_q;
	logic [lkvc_pkg::VAL_W-1:0]  val_q;

	logic [lkvc_pkg::KEY_W-1:0]  keys_q [N];
	logic [lkvc_pkg::VAL_W-1:0]  vals_q [N];
	logic [N-1:0]                valid_q;
	logic [lkvc_pkg::RANK_W-1:0] rank_q [N];
	logic [lkvc_pkg::CNT_W-1:0]  used_q;

	// lookup results
	logic [N-1:0]                hit_vec;
	logic [lkvc_pkg::IDX_W-1:0]  hit_idx, free_idx, old_idx;
	logic [lkvc_pkg::CMP_W-1:0]  cap_ext, limit, used_ext;
	logic                        room;

	logic                        hit_s2;
	logic                        insert_s2;
	logic [lkvc_pkg::IDX_W-1:0]  tgt_s2;

	// apply stage
	logic [lkvc_pkg::RANK_W-1:0] tgt_rank;
	logic                        is_put;
	logic                        do_touch;
	logic                        do_write;

	assign cap_ext  = lkvc_pkg::CMP_W'(cap_q);
	assign used_ext = lkvc_pkg::CMP_W'(used_q);

	always_comb begin
		if (cap_ext == '0) begin
			limit = lkvc_pkg::CMP_W'(1);
		end else if (cap_ext > lkvc_pkg::CMP_W'(N)) begin
			limit = lkvc_pkg::CMP_W'(N);
		end else begin
			limit = cap_ext;
		end
	end

	assign room = (used_ext < limit);

	always_comb begin
		hit_idx  = '0;
		old_idx  = '0;
		free_idx = '0;
		for (int i = 0; i < N; i++) begin
			hit_vec[i] = valid_q[i] && (keys_q[i] == key_q);
			if (hit_vec[i]) begin
				hit_idx = hit_idx | lkvc_pkg::IDX_W'(i);
			end
			// ranks form a permutation, so the least recent is the one at used-1
			if (valid_q[i] &&
			    (lkvc_pkg::CNT_W'(rank_q[i]) == used_q - lkvc_pkg::CNT_W'(1))) begin
				old_idx = old_idx | lkvc_pkg::IDX_W'(i);
			end
		end
		for (int i = N - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = lkvc_pkg::IDX_W'(i);
			end
		end
	end

	assign tgt_rank = rank_q[tgt_s2];
	assign is_put   = (cmd_q == lkvc_pkg::CMD_PUT);
	assign do_touch = hit_s2 || is_put;
	assign do_write = is_put;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= lkvc_pkg::CAP_RESET;
			valid_q <= '0;
			used_q  <= '0;
			for (int i = 0; i < N; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (cmd.apply && do_touch) begin
				for (int i = 0; i < N; i++) begin
					if (lkvc_pkg::IDX_W'(i) == tgt_s2) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (insert_s2 || rank_q[i] < tgt_rank)) begin
						rank_q[i] <= rank_q[i] + lkvc_pkg::RANK_W'(1);
					end
				end
				if (insert_s2) begin
					valid_q[tgt_s2] <= 1'b1;
					used_q          <= used_q + lkvc_pkg::CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			cmd_q <= req_command;
			key_q <= req_key;
			val_q <= req_value;
		end
		if (cmd.find) begin
			hit_s2    <= |hit_vec;
			insert_s2 <= !(|hit_vec) && room;
			if (|hit_vec) begin
				tgt_s2 <= hit_idx;
			end else if (room) begin
				tgt_s2 <= free_idx;
			end else begin
				tgt_s2 <= old_idx;
			end
		end
		if (cmd.apply) begin
			out_hit         <= hit_s2;
			out_evicted     <= is_put && !hit_s2 && !insert_s2;
			out_evicted_key <= (is_put && !hit_s2 && !insert_s2) ? keys_q[tgt_s2] : '0;
			if (is_put) begin
				out_read_value <= '0;
			end else if (hit_s2) begin
				out_read_value <= vals_q[tgt_s2];
			end else begin
				out_read_value <= lkvc_pkg::MISS_VALUE;
			end
			if (do_write) begin
				vals_q[tgt_s2] <= val_q;
				if (!hit_s2) begin
					keys_q[tgt_s2] <= key_q;
				end
			end
		end
	end

`ifndef SYNTH
	a_keys_unique: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("key held in more than one entry");

	a_used_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(used_q))
		else $error("fill count disagrees with valid entries");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && insert_s2) |-> !valid_q[tgt_s2])
		else $error("insert into an occupied entry");
`endif

endmodule
`default_nettype wire

// File: src/lru_key_value_cache_core.sv
// top level of the fully associative lru key-value cache
// a request is accepted, matched, then applied into the output register; apply waits until that register is free
// requests: a new one is taken only once the previous one is applied, set by the single match and apply sequence
// a result may wait in the output register while the next request is taken
// reset: arst_n clears valid bits, ranks, fill count and sets capacity_in_use to 16
`default_nettype none
module lru_key_value_cache_core (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire  [63:0]                   s_tdata,  // req_key[31:0], req_value[63:32]
	input  wire  [0:0]                    s_tuser,  // command[0]
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [63:0]                   m_tdata,  // read_value[31:0], evicted_key[63:32]
	output logic [1:0]                    m_tuser,  // hit[0], evicted[1]
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [lkvc_pkg::CFG_W-1:0]    cfg_data  // capacity_in_use
);

	lkvc_pkg::ctrl_cmd_t cmd;

	assign cfg_ready = 1'b1;

	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	lkvc_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.cfg_valid       (cfg_valid),
		.cfg_data        (cfg_data),
		.req_command     (s_tuser[0]),
		.req_key         (s_tdata[31:0]),
		.req_value       (s_tdata[63:32]),
		.out_hit         (m_tuser[0]),
		.out_read_value  (m_tdata[31:0]),
		.out_evicted     (m_tuser[1]),
		.out_evicted_key (m_tdata[63:32])
	);

endmodule
`default_nettype wire
